>>> design/swm_pkg.sv
// Package for the sliding window mean, minimum and maximum unit.
// Holds the default sizes and the controller state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // Default window length and sample width.
    localparam int C_WINDOW      = 60;
    localparam int C_SAMPLE_BITS = 24;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FILL,
        ST_WAIT
    } t_state;

endpackage

`default_nettype wire

>>> design/swm_cell.sv
// One storage cell of the sample chain: holds a sample and passes it on.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_shift,
    input  wire logic [SAMPLE_BITS-1:0] i_data,
    output logic      [SAMPLE_BITS-1:0] o_data
);

    logic [SAMPLE_BITS-1:0] r_data;

    // Take the neighbor's sample whenever the chain moves; the window starts at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> design/swm_div.sv
// Mean unit: divides the window sum by the constant window length with a reciprocal multiply.
// Uses swm_pkg for the default sizes.
`timescale 1ns / 1ps
`default_nettype none

module swm_div
    import swm_pkg::*;
#(
    parameter int WINDOW      = C_WINDOW,
    parameter int SAMPLE_BITS = C_SAMPLE_BITS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_start,
    input  wire logic [SAMPLE_BITS+$clog2(WINDOW)-1:0]   i_dividend,
    output logic                                         o_busy,
    output logic      [SAMPLE_BITS-1:0]                  o_quotient
);

    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int SHIFT      = SUM_BITS + $clog2(WINDOW);
    localparam int RECIP_BITS = SUM_BITS + 1;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;

    // The reciprocal is rounded up and carries enough fraction bits that the floor of the
    // scaled product equals the floor of the quotient for every sum that fits in SUM_BITS.
    localparam logic [RECIP_BITS-1:0] C_RECIP = RECIP_BITS'(
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [SUM_BITS-1:0]    r_sum;
    logic [SAMPLE_BITS-1:0] r_quot;
    logic                   r_busy;
    logic [PROD_BITS-1:0]   w_prod;

    // Scaled product of the registered sum and the reciprocal.
    assign w_prod = PROD_BITS'(r_sum) * PROD_BITS'(C_RECIP);

    // Control: busy for the one cycle in which the product is formed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    // Datapath: capture the sum at the start and the quotient in the cycle after.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= i_dividend;
        end
        if (r_busy) begin
            r_quot <= w_prod[SHIFT +: SAMPLE_BITS];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quot;

endmodule

`default_nettype wire

>>> design/sliding_window_mean_min_max_unit.sv
// A push that keeps its extremes passes through the update step and then the reciprocal-multiply
// mean unit, which registers the sum and then the quotient, before its result is loaded.
// A push that evicts the minimum or maximum rotates the sample chain once through the scan state,
// one cell a cycle; a fill shifts the new sample into every cell through the fill state.
// One item is in work at a time and the next beat is taken the cycle after the result is
// loaded; a result stall holds that load back.
// Reset is synchronous and active low; it zeroes every cell, the sum and both extremes.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_mean_min_max_unit
    import swm_pkg::*;
#(
    parameter int WINDOW      = C_WINDOW,
    parameter int SAMPLE_BITS = C_SAMPLE_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Input beats.
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       i_s_axis_tdata,  // sample
    input  wire logic                                   i_s_axis_tuser,  // kind
    // Result beats.
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    output logic      [((3*SAMPLE_BITS+7)/8)*8-1:0]     o_m_axis_tdata   // mean, minimum, maximum
);

    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int POS_BITS   = $clog2(WINDOW);
    localparam int OUT_DATA_W = ((3*SAMPLE_BITS+7)/8)*8;

    t_state                 r_state, n_state;
    logic                   r_kind;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SUM_BITS-1:0]    r_sum, n_sum;
    logic [SAMPLE_BITS-1:0] r_lo, n_lo;
    logic [SAMPLE_BITS-1:0] r_hi, n_hi;
    logic [POS_BITS-1:0]    r_cnt, n_cnt;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_mean, r_min, r_max;

    logic                   w_accept;
    logic                   w_shift;
    logic [SAMPLE_BITS-1:0] w_head;
    logic [SAMPLE_BITS-1:0] w_tail;
    logic [SAMPLE_BITS-1:0] w_cell [WINDOW];
    logic                   w_div_start;
    logic                   w_div_busy;
    logic [SAMPLE_BITS-1:0] w_quotient;
    logic                   w_load_out;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_tail   = w_cell[WINDOW-1];

    // Sample chain: cell 0 takes the head value, every other cell its left neighbor.
    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        if (k == 0) begin : g_first
            swm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_data  (w_head),
                .o_data  (w_cell[k])
            );
        end else begin : g_rest
            swm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_data  (w_cell[k-1]),
                .o_data  (w_cell[k])
            );
        end
    end

    // Mean divider, started with the updated sum.
    swm_div #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (n_sum),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_cnt       = r_cnt;
        w_shift     = 1'b0;
        w_head      = r_sample;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                w_div_start = 1'b1;
                n_cnt       = '0;
                if (r_kind) begin
                    // Fill: the sum is known at once, while the cells load in the fill state.
                    n_sum   = SUM_BITS'(r_sample) * SUM_BITS'(WINDOW);
                    n_lo    = r_sample;
                    n_hi    = r_sample;
                    n_state = ST_FILL;
                end else begin
                    // Push: the oldest sample drops off the tail.
                    w_shift = 1'b1;
                    n_sum   = r_sum - SUM_BITS'(w_tail) + SUM_BITS'(r_sample);
                    if (w_tail == r_lo || w_tail == r_hi) begin
                        n_lo    = '1;
                        n_hi    = '0;
                        n_state = ST_SCAN;
                    end else begin
                        if (r_sample < r_lo) begin
                            n_lo = r_sample;
                        end
                        if (r_sample > r_hi) begin
                            n_hi = r_sample;
                        end
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_SCAN: begin
                // Rotate the chain once, folding each tail value into the extremes.
                w_shift = 1'b1;
                w_head  = w_tail;
                if (w_tail < r_lo) begin
                    n_lo = w_tail;
                end
                if (w_tail > r_hi) begin
                    n_hi = w_tail;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == POS_BITS'(WINDOW - 1)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_FILL: begin
                w_shift = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == POS_BITS'(WINDOW - 1)) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!w_div_busy && (!r_out_valid || i_m_axis_tready)) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_cnt   <= n_cnt;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input capture and result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= i_s_axis_tuser;
            r_sample <= i_s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (w_load_out) begin
            r_mean <= w_quotient;
            r_min  <= r_lo;
            r_max  <= r_hi;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_max, r_min, r_mean});

    // An accepted beat always starts with the update step.
    a_accept_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_UPDATE))
        else $error("accepted beat did not enter the update step");

    // The divider must be free before a new division is started.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> !w_div_busy)
        else $error("divider still busy at the update step");

    // Extremes are ordered whenever the block is between items.
    a_lo_le_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_lo <= r_hi))
        else $error("minimum exceeds maximum");

    // A rescan ends after exactly one full rotation.
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_cnt == POS_BITS'(WINDOW - 1)) |=> (r_state == ST_WAIT))
        else $error("rescan did not end after one rotation");

endmodule

`default_nettype wire
